@@ src/waveform_minmax_column_envelope_defines.svh @@
// Assertion macros for the min/max column envelope block.
`ifndef WAVEFORM_MINMAX_COLUMN_ENVELOPE_DEFINES_SVH
`define WAVEFORM_MINMAX_COLUMN_ENVELOPE_DEFINES_SVH
`ifndef SYNTH
// Same-cycle implication, clocked on clk and disabled during reset.
`define WMCE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication, clocked on clk and disabled during reset.
`define WMCE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define WMCE_ASSERT_IMP(lbl, ante, cons, msg)
`define WMCE_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/wmce_pkg.sv @@
// Shared types and constants for the min/max column envelope block.
`default_nettype none
package wmce_pkg;

	localparam int MAX_COLUMNS = 4096;
	localparam int COL_W = $clog2(MAX_COLUMNS);

	localparam int SAMPLE_W = 16;
	localparam int SIZE_W = 16;
	localparam int HEIGHT_W = 12;
	localparam int OFFSET_W = 12;
	localparam int COLUMN_W = 12;
	localparam int CFG_IDX_W = 2;

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] CFG_SIXTEEN_BIT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PANEL_HEIGHT = 2'd2;

	localparam logic [SIZE_W-1:0] BIN_SIZE_RESET = 16'd1;
	localparam logic [HEIGHT_W-1:0] PANEL_HEIGHT_RESET = 12'd256;

	// Full-scale codes for the clipped test.
	localparam logic signed [SAMPLE_W-1:0] FS16_POS = 16'sd32767;
	localparam logic signed [SAMPLE_W-1:0] FS16_NEG = -16'sd32768;
	localparam logic signed [SAMPLE_W-1:0] FS8_POS = 16'sd127;
	localparam logic signed [SAMPLE_W-1:0] FS8_NEG = -16'sd128;

	// Scaling divides by full scale times two: 2^16 or 2^8.
	localparam int SHIFT16 = 16;
	localparam int SHIFT8 = 8;
	localparam int PROD_W = SAMPLE_W + HEIGHT_W + 1;

	typedef struct packed {
		logic                sixteen_bit;
		logic [SIZE_W-1:0]   bin_size;
		logic [HEIGHT_W-1:0] panel_height;
	} cfg_t;

	// One closed bin on its way to the scaler.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] bin_max;
		logic signed [SAMPLE_W-1:0] bin_min;
		logic [COL_W-1:0]           column;
		logic                       clipped;
		logic                       sixteen_bit;
	} bin_t;

	// Status of the fold stage, watched by the top level.
	typedef struct packed {
		logic             s1_valid;
		logic             go;
		logic             emit;
		logic             last;
		logic [COL_W-1:0] column;
	} fold_st_t;

endpackage
`default_nettype wire

@@ src/wmce_bin_fold.sv @@
// Input register and running min/max fold that closes bins into stage two.
`default_nettype none
module wmce_bin_fold
	import wmce_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 sample_valid,
	output logic                      sample_stall,
	input  wire logic [SAMPLE_W-1:0]  sample_code,
	input  wire logic                 last_sample,
	output bin_t                      bin_s2,
	output logic                      bin_valid_s2,
	input  wire logic                 bin_take,
	output fold_st_t                  st
);

	logic                       valid_s1;
	logic signed [SAMPLE_W-1:0] value_s1;
	logic                       last_s1;

	logic signed [SAMPLE_W-1:0] max_q, min_q;
	logic [SIZE_W-1:0]          fill_q;
	logic [COL_W-1:0]           col_q;

	logic signed [SAMPLE_W-1:0] decoded;
	logic signed [SAMPLE_W-1:0] max_n, min_n;
	logic [SIZE_W-1:0]          fill_n, limit;
	logic                       emit, go, accept, s2_free, clip;

	// 8-bit samples are offset binary: flipping the top bit gives two's complement.
	assign decoded = cfg.sixteen_bit ? $signed(sample_code)
		: $signed({{8{~sample_code[7]}}, ~sample_code[7], sample_code[6:0]});

	assign max_n = (value_s1 > max_q) ? value_s1 : max_q;
	assign min_n = (value_s1 < min_q) ? value_s1 : min_q;
	assign fill_n = fill_q + 1'b1;
	assign limit = (cfg.bin_size == '0) ? SIZE_W'(1) : cfg.bin_size;
	assign emit = (fill_n >= limit) || last_s1;
	assign clip = cfg.sixteen_bit ? ((max_n == FS16_POS) || (min_n == FS16_NEG))
		: ((max_n == FS8_POS) || (min_n == FS8_NEG));

	assign s2_free = !bin_valid_s2 || bin_take;
	assign go = valid_s1 && (!emit || s2_free);
	assign sample_stall = valid_s1 && !go;
	assign accept = sample_valid && !sample_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			value_s1 <= decoded;
			last_s1 <= last_sample;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= '0;
			min_q <= '0;
			fill_q <= '0;
			col_q <= '0;
		end else if (go) begin
			if (emit) begin
				max_q <= '0;
				min_q <= '0;
				fill_q <= '0;
				if (last_s1 || col_q == COL_W'(MAX_COLUMNS - 1)) begin
					col_q <= '0;
				end else begin
					col_q <= col_q + 1'b1;
				end
			end else begin
				max_q <= max_n;
				min_q <= min_n;
				fill_q <= fill_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_valid_s2 <= 1'b0;
		end else if (go && emit) begin
			bin_valid_s2 <= 1'b1;
		end else if (bin_take) begin
			bin_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && emit) begin
			bin_s2.bin_max <= max_n;
			bin_s2.bin_min <= min_n;
			bin_s2.column <= col_q;
			bin_s2.clipped <= clip;
			bin_s2.sixteen_bit <= cfg.sixteen_bit;
		end
	end

	assign st.s1_valid = valid_s1;
	assign st.go = go;
	assign st.emit = emit;
	assign st.last = last_s1;
	assign st.column = col_q;

endmodule
`default_nettype wire

@@ src/wmce_peak_scale.sv @@
// Peak scaling multiply and the result register.
`default_nettype none
module wmce_peak_scale
	import wmce_pkg::*;
(
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic [HEIGHT_W-1:0]         panel_height,
	input  wire bin_t                        bin_s2,
	input  wire logic                        bin_valid_s2,
	output logic                             bin_take,
	output logic                             result_valid,
	input  wire logic                        result_stall,
	output logic [COLUMN_W-1:0]              column,
	output logic signed [OFFSET_W-1:0]       top_offset,
	output logic signed [OFFSET_W-1:0]       bottom_offset,
	output logic                             clipped
);

	logic signed [PROD_W-1:0] height_s;
	logic signed [PROD_W-1:0] top_prod, bot_prod, top_adj, bot_adj, top_sh, bot_sh;
	logic signed [PROD_W-1:0] bias;

	assign height_s = PROD_W'($signed({1'b0, panel_height}));
	assign top_prod = PROD_W'(bin_s2.bin_max) * height_s;
	assign bot_prod = PROD_W'(bin_s2.bin_min) * height_s;

	// A negative product is biased up so that the arithmetic shift truncates toward zero.
	assign bias = bin_s2.sixteen_bit ? PROD_W'((1 << SHIFT16) - 1) : PROD_W'((1 << SHIFT8) - 1);
	assign top_adj = top_prod + (top_prod[PROD_W-1] ? bias : '0);
	assign bot_adj = bot_prod + (bot_prod[PROD_W-1] ? bias : '0);
	assign top_sh = bin_s2.sixteen_bit ? (top_adj >>> SHIFT16) : (top_adj >>> SHIFT8);
	assign bot_sh = bin_s2.sixteen_bit ? (bot_adj >>> SHIFT16) : (bot_adj >>> SHIFT8);

	assign bin_take = bin_valid_s2 && (!result_valid || !result_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (bin_take) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (bin_take) begin
			column <= COLUMN_W'(bin_s2.column);
			top_offset <= top_sh[OFFSET_W-1:0];
			bottom_offset <= bot_sh[OFFSET_W-1:0];
			clipped <= bin_s2.clipped;
		end
	end

endmodule
`default_nettype wire

@@ src/waveform_minmax_column_envelope.sv @@
// Min/max column envelope: folds a PCM sample stream into per-column peaks.
//
// Samples enter on the sample channel (sample_valid, sample_stall, sample_code,
// last_sample) and one envelope per closed bin leaves on the result channel
// (result_valid, result_stall, column, top_offset, bottom_offset, clipped).
// A request moves when valid is high and stall is low.
// One sample is taken every cycle while sample_stall is low. A sample is held in the
// input register, where the running min/max fold is done; a bin it closes is then
// registered in the scaling stage and from there passes to the result register.
// The fold register and two peak multipliers in the scaling stage set that rate.
// When the receiver stalls, the scaling stage and the result register fill,
// and sample_stall rises only once a held sample would close a bin with nowhere
// to go. Samples that leave the bin open keep flowing.
// Reset clears the bin, the column counter and all valid flags, and loads
// sixteen_bit = 0, bin_size = 1 and panel_height = 256. The user must write registers
// through cfg_we/cfg_index/cfg_data only while the block is idle; the block does not enforce it.
`default_nettype none
`include "waveform_minmax_column_envelope_defines.svh"
module waveform_minmax_column_envelope
	import wmce_pkg::*;
(
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   cfg_we,
	input  wire logic [CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [SIZE_W-1:0]      cfg_data,
	input  wire logic                   sample_valid,
	output logic                        sample_stall,
	input  wire logic [SAMPLE_W-1:0]    sample_code,
	input  wire logic                   last_sample,
	output logic                        result_valid,
	input  wire logic                   result_stall,
	output logic [COLUMN_W-1:0]         column,
	output logic signed [OFFSET_W-1:0]  top_offset,
	output logic signed [OFFSET_W-1:0]  bottom_offset,
	output logic                        clipped
);

	cfg_t     cfg_q;
	bin_t     bin_s2;
	logic     bin_valid_s2;
	logic     bin_take;
	fold_st_t fold_st;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sixteen_bit <= 1'b0;
			cfg_q.bin_size <= BIN_SIZE_RESET;
			cfg_q.panel_height <= PANEL_HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SIXTEEN_BIT: cfg_q.sixteen_bit <= cfg_data[0];
				CFG_BIN_SIZE: cfg_q.bin_size <= cfg_data;
				CFG_PANEL_HEIGHT: cfg_q.panel_height <= cfg_data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	wmce_bin_fold u_fold (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.sample_code  (sample_code),
		.last_sample  (last_sample),
		.bin_s2       (bin_s2),
		.bin_valid_s2 (bin_valid_s2),
		.bin_take     (bin_take),
		.st           (fold_st)
	);

	wmce_peak_scale u_scale (
		.clk           (clk),
		.arst_n        (arst_n),
		.panel_height  (cfg_q.panel_height),
		.bin_s2        (bin_s2),
		.bin_valid_s2  (bin_valid_s2),
		.bin_take      (bin_take),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.column        (column),
		.top_offset    (top_offset),
		.bottom_offset (bottom_offset),
		.clipped       (clipped)
	);

	`WMCE_ASSERT_IMP(a_stall_needs_held, sample_stall, fold_st.s1_valid && fold_st.emit && bin_valid_s2, "sample stall without a blocked closing sample")
	`WMCE_ASSERT_NXT(a_last_resets_col, fold_st.go && fold_st.last, fold_st.column == '0, "column not cleared after last sample")
	`WMCE_ASSERT_NXT(a_result_drains, result_valid && !result_stall && !bin_valid_s2, !result_valid, "result repeated after it was taken")

endmodule
`default_nettype wire
